>>> design/ipv4hc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 header check and TTL update unit.
// No dependencies; every module of the unit imports this package.
package ipv4hc_pkg;

    localparam int MAX_WORDS = 30;
    localparam int IDX_W = $clog2(MAX_WORDS + 1);
    localparam int WORD_W = 16;
    localparam int OUT_TDATA_W = 56;

    localparam logic [IDX_W-1:0] WORD_TTL = IDX_W'(4);
    localparam logic [IDX_W-1:0] WORD_CHECK = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_WORDS);
    localparam logic [WORD_W-1:0] TTL_ONE = 16'h0100;

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_EXPIRED = 2'd1,
        VERDICT_BADSUM  = 2'd2
    } verdict_t;

    // Header totals as seen with the current word folded in.
    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] ttl_word;
        logic [WORD_W-1:0] checksum;
    } hdr_totals_t;

endpackage

>>> design/ipv4hc_in_reg.sv
`timescale 1ns / 1ps
// Input register for header words with stream handshake.
// Depends on ipv4hc_pkg.
module ipv4hc_in_reg
    import ipv4hc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              out_free,
    output logic              fire,
    output logic [WORD_W-1:0] word,
    output logic              last
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;
    logic              advance;
    logic              accept;

    // A non-final word never waits on the result side.
    assign advance       = !last_reg || out_free;
    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = valid_reg && advance;
    assign word          = word_reg;
    assign last          = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

endmodule

>>> design/ipv4hc_accum.sv
`timescale 1ns / 1ps
// Running one's-complement sum, word position and saved TTL/checksum words.
// Depends on ipv4hc_pkg.
module ipv4hc_accum
    import ipv4hc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [WORD_W-1:0] word,
    input  logic              last,
    output hdr_totals_t       totals
);

    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [WORD_W-1:0] ttl_reg;
    logic [WORD_W-1:0] ttl_next;
    logic [WORD_W-1:0] chk_reg;
    logic [WORD_W-1:0] chk_next;
    logic [WORD_W:0]   raw_sum;
    logic [WORD_W-1:0] folded;
    logic [WORD_W-1:0] eff_ttl;
    logic [WORD_W-1:0] eff_chk;

    assign raw_sum = {1'b0, sum_reg} + {1'b0, word};
    assign folded  = raw_sum[WORD_W-1:0] + WORD_W'(raw_sum[WORD_W]);
    assign eff_ttl = (idx_reg == WORD_TTL) ? word : ttl_reg;
    assign eff_chk = (idx_reg == WORD_CHECK) ? word : chk_reg;

    assign totals.sum      = folded;
    assign totals.ttl_word = eff_ttl;
    assign totals.checksum = eff_chk;

    always_comb
    begin
        sum_next = sum_reg;
        idx_next = idx_reg;
        ttl_next = ttl_reg;
        chk_next = chk_reg;
        if (fire)
        begin
            if (last)
            begin
                // clear for the next header
                sum_next = '0;
                idx_next = '0;
                ttl_next = '0;
                chk_next = '0;
            end
            else
            begin
                sum_next = folded;
                ttl_next = eff_ttl;
                chk_next = eff_chk;
                if (idx_reg < IDX_LIMIT)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
            ttl_reg <= '0;
            chk_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            idx_reg <= idx_next;
            ttl_reg <= ttl_next;
            chk_reg <= chk_next;
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LIMIT)
        else $error("word index beyond limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> idx_reg == '0 && sum_reg == '0 && ttl_reg == '0)
        else $error("state not cleared after last word");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last && idx_reg < IDX_LIMIT |=> idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("word index did not advance");

endmodule

>>> design/ipv4hc_result.sv
`timescale 1ns / 1ps
// Verdict, TTL decrement and incremental checksum update into the result register.
// Depends on ipv4hc_pkg.
module ipv4hc_result
    import ipv4hc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  hdr_totals_t            totals,
    output logic                   out_free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic              valid_reg;
    logic              valid_next;
    verdict_t          verdict_reg;
    verdict_t          verdict_next;
    logic [WORD_W-1:0] ttl_new_reg;
    logic [WORD_W-1:0] ttl_new_next;
    logic [WORD_W-1:0] upd_reg;
    logic [WORD_W-1:0] upd_next;
    logic [WORD_W-1:0] comp_reg;
    logic [WORD_W-1:0] comp_next;
    logic [WORD_W+1:0] upd_raw;
    logic [WORD_W:0]   upd_fold;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        ttl_new_next = totals.ttl_word - TTL_ONE;
        upd_raw      = {2'b00, totals.checksum} + {2'b00, totals.ttl_word}
                     + {2'b00, ~ttl_new_next};
        upd_fold     = {1'b0, upd_raw[WORD_W-1:0]} + (WORD_W+1)'(upd_raw[WORD_W+1:WORD_W]);
        upd_next     = upd_fold[WORD_W-1:0] + WORD_W'(upd_fold[WORD_W]);
        comp_next    = ~totals.sum;
        if (totals.ttl_word[WORD_W-1:8] <= 8'd1)
        begin
            verdict_next = VERDICT_EXPIRED;
        end
        else if (comp_next != '0)
        begin
            verdict_next = VERDICT_BADSUM;
        end
        else
        begin
            verdict_next = VERDICT_FORWARD;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict_next;
            ttl_new_reg <= ttl_new_next;
            upd_reg     <= upd_next;
            comp_reg    <= comp_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'b0, comp_reg, upd_reg, ttl_new_reg, verdict_reg};

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> verdict_reg != 2'd3)
        else $error("undefined verdict code");

    a_forward_sum_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && verdict_reg == VERDICT_FORWARD |-> comp_reg == '0)
        else $error("forward with bad checksum");

    a_expired_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && verdict_reg == VERDICT_EXPIRED
        |-> ttl_new_reg[WORD_W-1:8] == 8'hFF || ttl_new_reg[WORD_W-1:8] == 8'h00)
        else $error("expired verdict with live ttl");

endmodule

>>> design/ipv4_header_check_ttl_update_unit.sv
`timescale 1ns / 1ps
// IPv4 header check and TTL update unit: every accepted header word passes an
// input register and one add-and-fold stage; the word with tlast set yields one
// result word in the result register when it leaves the input register. One header
// word is taken per clock; the only stall comes from a result word that the
// master side has not yet taken while a last word waits behind it.
// Depends on ipv4hc_pkg, ipv4hc_in_reg, ipv4hc_accum, ipv4hc_result.
module ipv4_header_check_ttl_update_unit
    import ipv4hc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [WORD_W-1:0]      s_axis_tdata,   // header_word
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // verdict[1:0], new_ttl_word[17:2], new_checksum[33:18], computed_checksum[49:34]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic              out_free;
    logic              fire;
    logic [WORD_W-1:0] word;
    logic              last;
    hdr_totals_t       totals;

    ipv4hc_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .out_free      (out_free),
        .fire          (fire),
        .word          (word),
        .last          (last)
    );

    ipv4hc_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (word),
        .last   (last),
        .totals (totals)
    );

    ipv4hc_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire && last),
        .totals        (totals),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
